// File: hdl/rhcp_pkg.sv
// rhcp_pkg: shared types, character codes and field numbers for the read header coordinate parser
// no dependencies; used by rhcp_acc, rhcp_scan and read_header_coord_parser
package rhcp_pkg;

	// default saturation limit for positions and lengths
	localparam int MAX_LEN_DEF = 4095;

	// width of the position fields on the result beat
	localparam int OUT_POS_W = 12;

	// packed result beat width, padded to whole bytes
	localparam int RES_BITS = 1 + 8 + 16 + 32 + 32 + OUT_POS_W + OUT_POS_W;
	localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

	// character codes
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;

	// colon count at which each coordinate field closes
	localparam logic [2:0] FLD_LANE = 3'd4;
	localparam logic [2:0] FLD_TILE = 3'd5;
	localparam logic [2:0] FLD_X    = 3'd6;
	localparam logic [2:0] FLD_Y    = 3'd7;

	// number conversion phases
	typedef enum logic [1:0] {
		PH_LEAD,
		PH_DIGITS,
		PH_STOP
	} acc_phase_t;

	// control from the scanner to the number converter
	typedef struct packed {
		logic feed;
		logic clear;
	} acc_ctrl_t;

	// one result beat
	typedef struct packed {
		logic                 has_coords;
		logic [7:0]           lane_num;
		logic [15:0]          tile_num;
		logic [31:0]          x_coord;
		logic [31:0]          y_coord;
		logic [OUT_POS_W-1:0] prefix_len;
		logic [OUT_POS_W-1:0] suffix_start;
	} result_t;

endpackage

// File: hdl/read_header_coord_parser.sv
// read_header_coord_parser: top level, input register, scanner, converter and result register
// depends on rhcp_pkg, rhcp_acc and rhcp_scan
//
//  channel  | dir | bus fields (lowest bit first)                       | beats
//  ---------+-----+-----------------------------------------------------+----------------
//  s_ (in)  | in  | tdata: ch[7:0]; tlast: last                         | one per char
//  m_ (out) | out | tdata: has_coords, lane, tile, x, y, prefix, suffix | one per line
//
// one character is taken every cycle while no final character is held; the result of a line
// passes the input register, then is written to the result register as its last character moves on
// the per-character path is the times-ten add and sign select of the converter
// arst_n clears the input and result valid flags and all scan state
// while a result waits on m_tready, non-final characters still flow; a final character
// holds in the input register until the result register frees up
module read_header_coord_parser #(
	parameter int MAX_LEN = rhcp_pkg::MAX_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // ch[7:0]
	input  logic                       s_tlast,  // last character of the name line
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [rhcp_pkg::RES_W-1:0] m_tdata   // has_coords[0], lane_num[8:1],
	                                             // tile_num[24:9], x_coord[56:25],
	                                             // y_coord[88:57], prefix_len[100:89],
	                                             // suffix_start[112:101], zero pad
);

	logic                       s1_valid_q;
	logic [7:0]                 s1_ch_q;
	logic                       s1_last_q;
	logic                       advance;
	logic                       m_valid_q;
	logic [rhcp_pkg::RES_W-1:0] m_data_q;
	logic [31:0]                acc_value;
	rhcp_pkg::acc_ctrl_t        acc_ctrl;
	rhcp_pkg::result_t          result;

	// a beat in the input register moves on unless it ends a line and the
	// result register is still held
	assign advance  = s1_valid_q && (!s1_last_q || !m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	// payload of the input register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_ch_q   <= s_tdata;
			s1_last_q <= s_tlast;
		end
	end

	rhcp_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.ch     (s1_ch_q),
		.value  (acc_value)
	);

	rhcp_scan #(
		.MAX_LEN (MAX_LEN)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.ch        (s1_ch_q),
		.last      (s1_last_q),
		.acc_value (acc_value),
		.acc_ctrl  (acc_ctrl),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && s1_last_q) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_last_q) begin
			m_data_q <= {
				{(rhcp_pkg::RES_W - rhcp_pkg::RES_BITS){1'b0}},
				result.suffix_start,
				result.prefix_len,
				result.y_coord,
				result.x_coord,
				result.tile_num,
				result.lane_num,
				result.has_coords
			};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// a held result is never overwritten by the next line
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready |-> !(advance && s1_last_q))
		else $error("result register overwritten while held");

	// a result appears only after a final character moved on
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(advance && s1_last_q))
		else $error("result without a final character");

	// an empty input register always takes a beat
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input stalled with empty input register");

	// non-final characters are never held back by the output side
	a_char_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_last_q |-> advance)
		else $error("mid-line character stalled");

endmodule

// File: hdl/rhcp_acc.sv
// rhcp_acc: decimal field converter with leading whitespace, optional sign and 32-bit wrap
// depends on rhcp_pkg
module rhcp_acc (
	input  logic               clk,
	input  logic               arst_n,
	input  rhcp_pkg::acc_ctrl_t ctrl,
	input  logic [7:0]         ch,
	output logic [31:0]        value
);

	logic [31:0]           acc_q, acc_d;
	logic                  neg_q, neg_d;
	rhcp_pkg::acc_phase_t  phase_q, phase_d;
	logic                  is_ws, is_sign, is_digit;
	logic [31:0]           acc_next;
	logic [3:0]            digit;

	assign is_ws    = (ch == rhcp_pkg::CH_SPACE) ||
	                  (ch >= rhcp_pkg::CH_TAB && ch <= rhcp_pkg::CH_CR);
	assign is_sign  = (ch == rhcp_pkg::CH_PLUS) || (ch == rhcp_pkg::CH_MINUS);
	assign is_digit = (ch >= rhcp_pkg::CH_ZERO) && (ch <= rhcp_pkg::CH_NINE);
	assign digit    = 4'(ch - rhcp_pkg::CH_ZERO);

	// times ten as two shifts and an add, wrapping at 32 bits
	assign acc_next = (acc_q << 3) + (acc_q << 1) + {28'd0, digit};

	always_comb begin
		acc_d   = acc_q;
		neg_d   = neg_q;
		phase_d = phase_q;
		if (ctrl.clear) begin
			acc_d   = '0;
			neg_d   = 1'b0;
			phase_d = rhcp_pkg::PH_LEAD;
		end else if (ctrl.feed) begin
			unique case (phase_q)
				rhcp_pkg::PH_LEAD: begin
					if (is_ws) begin
						phase_d = rhcp_pkg::PH_LEAD;
					end else if (is_sign) begin
						neg_d   = (ch == rhcp_pkg::CH_MINUS);
						phase_d = rhcp_pkg::PH_DIGITS;
					end else if (is_digit) begin
						acc_d   = acc_next;
						phase_d = rhcp_pkg::PH_DIGITS;
					end else begin
						phase_d = rhcp_pkg::PH_STOP;
					end
				end
				rhcp_pkg::PH_DIGITS: begin
					if (is_digit) begin
						acc_d = acc_next;
					end else begin
						phase_d = rhcp_pkg::PH_STOP;
					end
				end
				rhcp_pkg::PH_STOP: begin
					phase_d = rhcp_pkg::PH_STOP;
				end
				default: begin
					phase_d = rhcp_pkg::PH_STOP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			phase_q <= rhcp_pkg::PH_LEAD;
		end else begin
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			phase_q <= phase_d;
		end
	end

	assign value = neg_q ? (32'd0 - acc_q) : acc_q;

endmodule

// File: hdl/rhcp_scan.sv
// rhcp_scan: colon counting, field capture and position tracking for one name line
// depends on rhcp_pkg; drives rhcp_acc through an acc_ctrl_t bundle
module rhcp_scan #(
	parameter int MAX_LEN = rhcp_pkg::MAX_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          ch,
	input  logic                last,
	input  logic [31:0]         acc_value,
	output rhcp_pkg::acc_ctrl_t acc_ctrl,
	output rhcp_pkg::result_t   result
);

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

	logic [2:0]       colon_count_q, colon_count_d, cnt_inc;
	logic [POS_W-1:0] char_pos_q, char_pos_d;
	logic [POS_W-1:0] last_colon_q, last_colon_d;
	logic [POS_W-1:0] coord_start_q, coord_start_d;
	logic [POS_W-1:0] coord_end_q, coord_end_d;
	logic             scan_done_q, scan_done_d;
	logic [7:0]       lane_q, lane_d;
	logic [15:0]      tile_q, tile_d;
	logic [31:0]      x_q, x_d;
	logic [31:0]      y_q, y_d;
	logic             colon, space, active;
	logic [POS_W-1:0] len, lcp_inc, prefix_pos;
	logic [31:0]      prefix_ext, suffix_ext, len_ext;

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
		return (v >= POS_MAX) ? POS_MAX : v + 1'b1;
	endfunction

	assign colon   = (ch == rhcp_pkg::CH_COLON);
	assign space   = (ch == rhcp_pkg::CH_SPACE);
	assign active  = !scan_done_q;
	assign cnt_inc = colon ? colon_count_q + 3'd1 : colon_count_q;
	assign len     = sat_inc(char_pos_q);
	assign lcp_inc = sat_inc(last_colon_q);

	always_comb begin
		colon_count_d = colon_count_q;
		last_colon_d  = last_colon_q;
		coord_start_d = coord_start_q;
		coord_end_d   = coord_end_q;
		scan_done_d   = scan_done_q;
		lane_d        = lane_q;
		tile_d        = tile_q;
		x_d           = x_q;
		y_d           = y_q;
		char_pos_d    = len;
		if (active) begin
			colon_count_d = cnt_inc;
			if (colon || space) begin
				unique case (cnt_inc)
					rhcp_pkg::FLD_LANE: begin
						lane_d        = acc_value[7:0];
						coord_start_d = lcp_inc;
					end
					rhcp_pkg::FLD_TILE: tile_d = acc_value[15:0];
					rhcp_pkg::FLD_X: begin
						// a space after the sixth colon closes y, not x
						if (colon) begin
							x_d = acc_value;
						end else begin
							y_d = acc_value;
						end
					end
					rhcp_pkg::FLD_Y: y_d = acc_value;
					default: begin
						lane_d = lane_q;
					end
				endcase
			end
			if (colon) begin
				last_colon_d = char_pos_q;
			end
			if (space || (colon && cnt_inc == rhcp_pkg::FLD_Y)) begin
				coord_end_d = char_pos_q;
				scan_done_d = 1'b1;
			end
		end
	end

	assign acc_ctrl.clear = step && (last || (active && colon));
	assign acc_ctrl.feed  = step && active && !colon && !space;

	// result as seen after this character
	assign prefix_pos = coord_start_d - 1'b1;
	assign prefix_ext = 32'(prefix_pos);
	assign suffix_ext = 32'(coord_end_d);
	assign len_ext    = 32'(len);

	always_comb begin
		result = '0;
		if (coord_start_d != '0 && coord_end_d != '0) begin
			result.has_coords   = 1'b1;
			result.lane_num     = lane_d;
			result.tile_num     = tile_d;
			result.x_coord      = x_d;
			result.y_coord      = y_d;
			result.prefix_len   = prefix_ext[rhcp_pkg::OUT_POS_W-1:0];
			result.suffix_start = suffix_ext[rhcp_pkg::OUT_POS_W-1:0];
		end else begin
			result.prefix_len   = len_ext[rhcp_pkg::OUT_POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colon_count_q <= '0;
			char_pos_q    <= '0;
			last_colon_q  <= '0;
			coord_start_q <= '0;
			coord_end_q   <= '0;
			scan_done_q   <= 1'b0;
			lane_q        <= '0;
			tile_q        <= '0;
			x_q           <= '0;
			y_q           <= '0;
		end else if (step) begin
			if (last) begin
				colon_count_q <= '0;
				char_pos_q    <= '0;
				last_colon_q  <= '0;
				coord_start_q <= '0;
				coord_end_q   <= '0;
				scan_done_q   <= 1'b0;
				lane_q        <= '0;
				tile_q        <= '0;
				x_q           <= '0;
				y_q           <= '0;
			end else begin
				colon_count_q <= colon_count_d;
				char_pos_q    <= char_pos_d;
				last_colon_q  <= last_colon_d;
				coord_start_q <= coord_start_d;
				coord_end_q   <= coord_end_d;
				scan_done_q   <= scan_done_d;
				lane_q        <= lane_d;
				tile_q        <= tile_d;
				x_q           <= x_d;
				y_q           <= y_d;
			end
		end
	end

	// a finished line leaves the scanner cleared
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> colon_count_q == '0 && char_pos_q == '0 && !scan_done_q)
		else $error("scanner not cleared after end of line");

	// the scan stops no later than the seventh colon
	a_stop_at_seven: assert property (@(posedge clk) disable iff (!arst_n)
		colon_count_q == rhcp_pkg::FLD_Y |-> scan_done_q)
		else $error("scan still running after seventh colon");

	// a closed scan has a stop position that never runs past the line
	a_end_before_pos: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done_q |-> coord_end_q < char_pos_q || char_pos_q == POS_MAX)
		else $error("stop position beyond current position");

endmodule

// File: tb/read_header_coord_parser_test.sv
// read_header_coord_parser_test: self-checking bench for the read name coordinate parser
// streams name lines a character per beat and checks each line's result beat field by field
// depends on rhcp_pkg and read_header_coord_parser
`timescale 1ns / 100ps

module read_header_coord_parser_test;
	import rhcp_pkg::*;

	localparam int LEN_MAX      = MAX_LEN_DEF;
	localparam int WATCHDOG_MAX = 2000;   // cycles with no beat on either side
	localparam int HOLD_CYCLES  = 400;    // long receiver hold-off for back-pressure
	localparam int PHASE_CHARS  = 475;    // random characters per idling phase

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;    // ch[7:0]
	logic s_tlast = 1'b0;        // last character of the line
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [RES_W-1:0] m_tdata;   // has_coords, lane, tile, x, y, prefix, suffix (lsb first)

	// stimulus and expectation stores
	char_beat_t char_queue[$];
	result_t coord_results[$];
	logic [7:0] line_buf[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int phase_chars = 0;

	// back-pressure hold-off, counted in its own process
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	// predictor state for the line being parsed
	logic [2:0] hdr_colons;
	int hdr_pos;
	int hdr_last_colon;
	int hdr_field_start;
	int hdr_field_end;
	logic hdr_done;
	logic [31:0] num_acc;
	acc_phase_t num_phase;
	logic num_neg;
	logic [7:0] lane_val;
	logic [15:0] tile_val;
	logic [31:0] x_val;
	logic [31:0] y_val;

	read_header_coord_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int pos_step(input int v);
		return (v >= LEN_MAX) ? LEN_MAX : v + 1;
	endfunction

	task automatic clear_number();
		num_acc = '0;
		num_phase = PH_LEAD;
		num_neg = 1'b0;
	endtask

	task automatic clear_parser();
		hdr_colons = '0;
		hdr_pos = 0;
		hdr_last_colon = 0;
		hdr_field_start = 0;
		hdr_field_end = 0;
		hdr_done = 1'b0;
		clear_number();
		lane_val = '0;
		tile_val = '0;
		x_val = '0;
		y_val = '0;
	endtask

	// atoi-style conversion: whitespace, optional sign, digits, stop at anything else
	task automatic feed_number(input logic [7:0] c);
		if (num_phase == PH_LEAD) begin
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
				return;
			if (c == CH_PLUS || c == CH_MINUS) begin
				num_neg = (c == CH_MINUS);
				num_phase = PH_DIGITS;
				return;
			end
			num_phase = PH_DIGITS;
		end
		if (num_phase == PH_DIGITS) begin
			if (c >= CH_ZERO && c <= CH_NINE)
				num_acc = num_acc * 32'd10 + 32'(c - CH_ZERO);
			else
				num_phase = PH_STOP;
		end
	endtask

	// one accepted character; a final character queues the line's expected result
	task automatic parse_header_char(input logic [7:0] c, input logic fin);
		logic is_colon;
		logic is_space;
		logic [31:0] v;
		result_t r;
		is_colon = (c == CH_COLON);
		is_space = (c == CH_SPACE);
		if (!hdr_done) begin
			if (is_colon)
				hdr_colons = hdr_colons + 3'd1;
			if ((is_colon || is_space) && hdr_colons >= FLD_LANE) begin
				v = num_neg ? -num_acc : num_acc;
				case (hdr_colons)
				FLD_LANE: begin
					lane_val = v[7:0];
					hdr_field_start = pos_step(hdr_last_colon);
				end
				FLD_TILE: tile_val = v[15:0];
				FLD_X: begin
					// a space after the sixth colon closes y, not x
					if (is_colon)
						x_val = v;
					else
						y_val = v;
				end
				default: y_val = v;
				endcase
			end
			if (is_colon) begin
				hdr_last_colon = hdr_pos;
				clear_number();
			end
			if (is_space || (is_colon && hdr_colons == FLD_Y)) begin
				hdr_field_end = hdr_pos;
				hdr_done = 1'b1;
			end else if (!is_colon) begin
				feed_number(c);
			end
		end
		hdr_pos = pos_step(hdr_pos);
		if (fin) begin
			r = '0;
			if (hdr_field_start > 0 && hdr_field_end > 0) begin
				r.has_coords = 1'b1;
				r.lane_num = lane_val;
				r.tile_num = tile_val;
				r.x_coord = x_val;
				r.y_coord = y_val;
				r.prefix_len = OUT_POS_W'(hdr_field_start - 1);
				r.suffix_start = OUT_POS_W'(hdr_field_end);
			end else begin
				// no coordinate block: only the line length is reported
				r.prefix_len = OUT_POS_W'(hdr_pos);
			end
			coord_results.push_back(r);
			clear_parser();
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 100)
			$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// ---------------------------------------------------------------- line builders

	task automatic add_char(input logic [7:0] c);
		line_buf.push_back(c);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	// move the built line onto the beat queue, last flag on its final character
	task automatic emit_line();
		for (int i = 0; i < line_buf.size(); i++)
			char_queue.push_back('{ch: line_buf[i], last: (i == line_buf.size() - 1)});
		phase_chars += line_buf.size();
		line_buf.delete();
	endtask

	task automatic add_word();
		int n;
		n = $urandom_range(0, 6);
		repeat (n) begin
			if ($urandom_range(3) == 0)
				add_char(CH_ZERO + 8'($urandom_range(9)));
			else
				add_char(8'h41 + 8'($urandom_range(25)));
		end
	endtask

	// number text with the odd leading whitespace, sign, overlong run or trailing junk
	task automatic add_number(input int max_digits);
		int n;
		int r;
		if ($urandom_range(9) == 0)
			add_char(CH_TAB + 8'($urandom_range(4)));
		r = $urandom_range(9);
		if (r < 2)
			add_char(CH_MINUS);
		else if (r == 2)
			add_char(CH_PLUS);
		n = ($urandom_range(7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, max_digits);
		repeat (n)
			add_char(CH_ZERO + 8'($urandom_range(9)));
		if ($urandom_range(9) == 0) begin
			add_char(8'h61 + 8'($urandom_range(25)));
			if ($urandom_range(1))
				add_char(CH_ZERO + 8'($urandom_range(9)));
		end
	endtask

	// anything at all after the scan has stopped
	task automatic add_tail();
		repeat ($urandom_range(0, 12))
			add_char(8'($urandom_range(255)));
	endtask

	task automatic random_line();
		int r;
		int n;
		string soup;
		soup = ":: 0123456789+-\t\013a";
		r = $urandom_range(99);
		if (r < 55) begin
			// well-formed header with random content
			repeat (3) begin
				add_word();
				add_char(CH_COLON);
			end
			add_number(2);
			add_char(CH_COLON);
			add_number(5);
			add_char(CH_COLON);
			add_number(6);
			add_char(CH_COLON);
			add_number(6);
			case ($urandom_range(3))
			0: begin
				add_char(CH_SPACE);
				add_tail();
			end
			1: begin
				add_char(CH_COLON);
				add_tail();
			end
			2: ;
			default: add_char(CH_SPACE);
			endcase
		end else if (r < 70) begin
			// broken header: wrong field count, early spaces
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(1))
					add_number(4);
				else
					add_word();
				if (i != n - 1)
					add_char(($urandom_range(5) == 0) ? CH_SPACE : CH_COLON);
			end
			if (line_buf.size() == 0)
				add_char(CH_COLON);
		end else if (r < 85) begin
			// raw bytes
			repeat ($urandom_range(1, 24))
				add_char(8'($urandom_range(255)));
		end else begin
			// separators, signs and digits mixed
			repeat ($urandom_range(1, 30))
				add_char(soup[$urandom_range(soup.len() - 1)]);
		end
		emit_line();
	endtask

	task automatic wait_queue_empty();
		while (char_queue.size() != 0)
			@(negedge clk);
	endtask

	// ---------------------------------------------------------------- driver

	// a beat is taken at an edge where tvalid and tready are both high
	always @(posedge clk) begin : drive_chars
		char_beat_t nxt;
		if (s_tvalid && s_tready)
			parse_header_char(s_tdata, s_tlast);
		if (!s_tvalid || s_tready) begin
			if (arst_n && char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = char_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.ch;
				s_tlast <= nxt.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (m_tvalid && m_tready) begin
			got.has_coords = m_tdata[0];
			got.lane_num = m_tdata[8:1];
			got.tile_num = m_tdata[24:9];
			got.x_coord = m_tdata[56:25];
			got.y_coord = m_tdata[88:57];
			got.prefix_len = m_tdata[100:89];
			got.suffix_start = m_tdata[112:101];
			if (coord_results.size() == 0) begin
				report_mismatch($sformatf("result beat with no line outstanding: %h", m_tdata));
			end else begin
				want = coord_results.pop_front();
				check_field("has_coords", got.has_coords, want.has_coords);
				check_field("lane_num", got.lane_num, want.lane_num);
				check_field("tile_num", got.tile_num, want.tile_num);
				check_field("x_coord", got.x_coord, want.x_coord);
				check_field("y_coord", got.y_coord, want.y_coord);
				check_field("prefix_len", got.prefix_len, want.prefix_len);
				check_field("suffix_start", got.suffix_start, want.suffix_start);
			end
		end
		m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	// long hold-off of the receiver while the sender keeps offering
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ---------------------------------------------------------------- watchdog

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_MAX) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("read_header_coord_parser_test failed");
		$finish;
	end

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		string directed_lines[$];
		clear_parser();
		directed_lines = '{
			"A1:7:FC9:3:1101:1234:5678 1:N:0:ACGT",  // typical, space closes y
			"I:R:F:8:2204:99:100:UMI",               // seventh colon closes y
			"plain_name",                            // no colons at all
			"x",                                     // single character line
			":",
			"a:b:c",                                 // lane never reached
			"a:b:c:d:e",                             // lane started, scan never stops
			"a:b:c:7 tail",                          // stop before the lane field
			" lead:b:c:1:2:3:4",                     // stop at position zero
			"a:b:c:12:34 z",                         // space after colon four rewrites lane
			"a:b:c:12:34:56 z",                      // space after colon five gives tile
			"a:b:c:\t\v\f\n\015-5:+7:-0:4294967295:",
			"a:b:c:999:99999999999:12ab34:--3 q",    // wrap and early stops
			":::::::",                               // empty fields
			"q:r:s:1:2:3:4:5::: 6",                  // colons after the scan stops are not counted
			"h:\377\200\001:c:+-3:-:+:00042 "
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines with no idling
		foreach (directed_lines[i]) begin
			add_str(directed_lines[i]);
			emit_line();
		end
		wait_queue_empty();

		// random lines in four idling phases
		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
				hold_req = 1'b1;
			end
			1: begin
				send_idle_pct = 75;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 75;
			end
			default: begin
				send_idle_pct = 29;
				recv_stall_pct = 29;
			end
			endcase
			phase_chars = 0;
			while (phase_chars < PHASE_CHARS)
				random_line();
			if (p == 3) begin
				// colons only after the position counter has saturated
				repeat (LEN_MAX + 5)
					add_char(8'h4e);
				add_str(":1:2:3:4:5:6:7 x");
				emit_line();
				// saturated length with no coordinates
				repeat (LEN_MAX + 100)
					add_char(8'h41 + 8'($urandom_range(25)));
				emit_line();
			end
			wait_queue_empty();
		end

		// drain, then allow for the two register stages
		while (char_queue.size() != 0 || s_tvalid || coord_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);

		if (coord_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", coord_results.size()));
		if (mismatch_count == 0)
			$display("read_header_coord_parser_test passed");
		else
			$display("read_header_coord_parser_test failed");
		$finish;
	end

endmodule

// File: files.f
hdl/rhcp_pkg.sv
hdl/rhcp_acc.sv
hdl/rhcp_scan.sv
hdl/read_header_coord_parser.sv
tb/read_header_coord_parser_test.sv
